// File: src/positional_list_engine_assert.svh
// Assertion macros shared by the checker files of the positional list engine.
// Depends on nothing; expects clk and rst_n in the scope that uses it.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define PLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define PLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs across reset.
`define PLE_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ple_pkg.sv
// Package for the positional list engine: sizes, operation codes, cell control.
// No dependencies.
package ple_pkg;

  localparam int DEPTH      = 32;
  localparam int WORD_WIDTH = 32;

  localparam int POS_W   = 6;   // position field
  localparam int FIELD_W = 32;  // value / element fields
  localparam int OCC_W   = 6;   // occupancy field
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2
  } action_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic              shift_up;    // insert: open a gap at tgt
    logic              shift_down;  // delete: close the gap at tgt
    logic [IDX_W-1:0]  tgt;         // 0-based target index
    word_t             value;       // word loaded at tgt on insert
  } cell_ctl_t;

endpackage

// File: src/ple_cell.sv
// One storage cell of the positional list row.
// Depends on ple_pkg.
module ple_cell (
  input  logic                    clk,
  input  logic [ple_pkg::IDX_W-1:0] idx,        // this cell's fixed place in the row
  input  ple_pkg::cell_ctl_t      ctl,
  input  ple_pkg::word_t          from_lower,
  input  ple_pkg::word_t          from_upper,
  output ple_pkg::word_t          word_o,
  output ple_pkg::word_t          rd_o
);

  ple_pkg::word_t word_r;

  always_ff @(posedge clk) begin
    if (ctl.shift_up) begin
      if (idx == ctl.tgt) begin
        word_r <= ctl.value;
      end else if (idx > ctl.tgt) begin
        word_r <= from_lower;
      end
    end else if (ctl.shift_down && (idx >= ctl.tgt)) begin
      word_r <= from_upper;
    end
  end

  assign word_o = word_r;
  // only the addressed cell drives the shared read bus
  assign rd_o   = (idx == ctl.tgt) ? word_r : '0;

endmodule

// File: src/positional_list_engine.sv
// Top level of the positional list engine: control, count and result register.
// Depends on ple_pkg and ple_cell.
//
// An ordered list of up to ple_pkg::DEPTH words held in a row of cells. Each
// input item is one operation (read, insert or delete at a 1-based position);
// each produces exactly one result item carrying a fail flag, the element read
// or removed, and the entry count after the operation. Refused operations
// (bad position, insert into a full list, read/delete on an empty list,
// unknown action) leave the list untouched and return element zero. The
// block takes one item per clock while the result register is empty or
// being drained (in_tready): on an accepted insert or delete each cell at or
// above the target loads its lower or upper neighbor (or the new value) in
// the same edge, and the result lands in a single output register, raising
// out_tvalid in the cycle after acceptance. There is no clearing pass.
module positional_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [5:0] position, [37:6] value, [39:38] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] element, [37:32] occupancy, [39:38] zero
  output logic        out_tuser   // [0] failed
);

  localparam int D = ple_pkg::DEPTH;

  // input unpacking
  logic [ple_pkg::POS_W-1:0]   position;
  logic [ple_pkg::FIELD_W-1:0] value;
  ple_pkg::action_t            action;

  assign position = in_tdata[5:0];
  assign value    = in_tdata[37:6];
  assign action   = ple_pkg::action_t'(in_tuser);

  logic accept;
  assign in_tready = !out_tvalid || out_tready;
  assign accept    = in_tvalid && in_tready;

  // count and result registers
  logic [ple_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        failed_r, failed_nxt;
  logic [ple_pkg::FIELD_W-1:0] element_r, element_nxt;
  logic [ple_pkg::OCC_W-1:0]   occ_r, occ_nxt;

  // position checks, all in one common width
  logic [ple_pkg::CMP_W-1:0] pos_w, cnt_w;
  logic                      pos_nonzero, in_list, in_list_ins, has_room;

  assign pos_w       = ple_pkg::CMP_W'(position);
  assign cnt_w       = ple_pkg::CMP_W'(count_r);
  assign pos_nonzero = (position != '0);
  assign in_list     = pos_nonzero && (pos_w <= cnt_w);
  assign in_list_ins = pos_nonzero && (pos_w <= cnt_w + ple_pkg::CMP_W'(1));
  assign has_room    = (cnt_w < ple_pkg::CMP_W'(D));

  // cell row
  ple_pkg::cell_ctl_t ctl;
  ple_pkg::word_t     words [D];
  ple_pkg::word_t     rds   [D];
  ple_pkg::word_t     rd_word;
  logic               op_ok;

  always_comb begin
    op_ok          = 1'b0;
    ctl.shift_up   = 1'b0;
    ctl.shift_down = 1'b0;
    ctl.tgt        = ple_pkg::IDX_W'(pos_w - ple_pkg::CMP_W'(1));
    ctl.value      = ple_pkg::word_t'(value);
    unique case (action)
      ple_pkg::ACT_READ: begin
        op_ok = in_list;
      end
      ple_pkg::ACT_INSERT: begin
        op_ok        = has_room && in_list_ins;
        ctl.shift_up = accept && op_ok;
      end
      ple_pkg::ACT_DELETE: begin
        op_ok          = in_list;
        ctl.shift_down = accept && op_ok;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    ple_pkg::word_t lower_w, upper_w;
    if (i == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_mid_lo
      assign lower_w = words[i-1];
    end
    if (i == D - 1) begin : g_last
      assign upper_w = words[i];
    end else begin : g_mid_hi
      assign upper_w = words[i+1];
    end
    ple_cell u_cell (
      .clk        (clk),
      .idx        (ple_pkg::IDX_W'(i)),
      .ctl        (ctl),
      .from_lower (lower_w),
      .from_upper (upper_w),
      .word_o     (words[i]),
      .rd_o       (rds[i])
    );
  end

  // one-hot read bus: at most one cell drives nonzero
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < D; i++) begin
      rd_word = rd_word | rds[i];
    end
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    failed_nxt    = failed_r;
    element_nxt   = element_r;
    occ_nxt       = occ_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      failed_nxt    = !op_ok;
      element_nxt   = '0;
      if (ctl.shift_up) begin
        count_nxt = count_r + ple_pkg::CNT_W'(1);
      end else if (ctl.shift_down) begin
        count_nxt = count_r - ple_pkg::CNT_W'(1);
      end
      if (op_ok && (action != ple_pkg::ACT_INSERT)) begin
        element_nxt = ple_pkg::FIELD_W'($signed(rd_word));
      end
      occ_nxt = ple_pkg::OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    failed_r  <= failed_nxt;
    element_r <= element_nxt;
    occ_r     <= occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = failed_r;
  assign out_tdata  = {2'b00, occ_r, element_r};

endmodule

// File: src/ple_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
// Depends on positional_list_engine_assert.svh.
`include "positional_list_engine_assert.svh"

module ple_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // no result may appear right out of reset
  `PLE_ASSERT_RST(a_rst_idle, !rst_n, !out_tvalid, "result valid after reset")
  // an empty result register never blocks the input
  `PLE_ASSERT_IMP(a_ready_empty, !out_tvalid, in_tready, "stalled with empty output")
  // a refused operation carries a zero element
  `PLE_ASSERT_IMP(a_fail_zero, out_tvalid && out_tuser, out_tdata[31:0] == 32'd0,
                  "refused item with nonzero element")
  // a stalled result holds
  `PLE_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata) && $stable(out_tuser),
                  "stalled result changed")

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);
